// File: rtl/ethernet_rx_filter_crc_check_assert.svh
// Assertion macros for the Ethernet receive filter.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ETHERNET_RX_FILTER_CRC_CHECK_ASSERT_SVH
`define ETHERNET_RX_FILTER_CRC_CHECK_ASSERT_SVH

// A property that must hold at every rising clock edge outside reset.
`define ERFCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A condition that must never be true outside reset.
`define ERFCC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/erfcc_pkg.sv
// Shared types, constants and functions of the Ethernet receive filter.
// Used by every module of the block; depends on nothing.
package erfcc_pkg;

    typedef enum logic [2:0] {
        V_ACCEPT   = 3'd0,
        V_ADDR_REJ = 3'd1,
        V_CRC_REJ  = 3'd2,
        V_RUNT     = 3'd3,
        V_OVERSIZE = 3'd4
    } t_verdict;

    typedef enum logic [2:0] {
        FT_IPV4  = 3'd0,
        FT_ARP   = 3'd1,
        FT_RARP  = 3'd2,
        FT_814C  = 3'd3,
        FT_IPX   = 3'd4,
        FT_IPV6  = 3'd5,
        FT_OTHER = 3'd6
    } t_frame_type;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_RARP = 16'h8035;
    localparam logic [15:0] ETYPE_814C = 16'h814C;
    localparam logic [15:0] ETYPE_IPX  = 16'h8137;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

    localparam int MAC_BYTES   = 6;
    localparam int TYPE_HI     = 12;
    localparam int TYPE_LO     = 13;
    localparam int HDR_LEN     = 14;
    localparam int MIN_FRAME   = 18;
    localparam int PAYLOAD_CAP = 2048;

    localparam logic       CFG_MAC0 = 1'b0;
    localparam logic       CFG_MAC1 = 1'b1;
    localparam logic [47:0] MAC0_RESET = 48'h1111_1111_1111;
    localparam logic [47:0] MAC1_RESET = 48'h4437_E689_CB7F;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef struct packed {
        t_verdict    verdict;
        t_frame_type frame_type;
        logic [11:0] payload_length;
        logic [31:0] computed_check;
    } t_result;

    // Reflected CRC-32 update by one byte, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_frame_type type_class(input logic [15:0] t);
        t_frame_type f;
        unique case (t)
            ETYPE_IPV4: f = FT_IPV4;
            ETYPE_ARP:  f = FT_ARP;
            ETYPE_RARP: f = FT_RARP;
            ETYPE_814C: f = FT_814C;
            ETYPE_IPX:  f = FT_IPX;
            ETYPE_IPV6: f = FT_IPV6;
            default:    f = FT_OTHER;
        endcase
        return f;
    endfunction

    // Byte k of an address, byte 0 being the most significant.
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        logic [7:0] r;
        unique case (k)
            3'd0:    r = mac[47:40];
            3'd1:    r = mac[39:32];
            3'd2:    r = mac[31:24];
            3'd3:    r = mac[23:16];
            3'd4:    r = mac[15:8];
            3'd5:    r = mac[7:0];
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ethernet_rx_filter_crc_check.sv
// Channel     Dir  Handshake                     Content
// s_axis      in   s_axis_tvalid/s_axis_tready   frame byte, tlast on final byte
// m_axis      out  m_axis_tvalid/m_axis_tready   verdict, frame type, length, CRC
// cfg         in   i_cfg_we                      accepted addresses 0 and 1
//
// One byte beat per cycle; a verdict passes the input register and then the output
// register after the frame's last beat. The rate is set by the single-byte CRC-32
// xor network fed from the tail delay line. A final beat waits in the input register
// while a previous verdict is not yet taken; other beats keep flowing. Reset is
// synchronous and clears all frame state; addresses return to their defaults.
//
// Top level of the Ethernet receive filter with CRC-32 check.
// Depends on erfcc_pkg, erfcc_in_stage, erfcc_frame_core and the assertion header.
`include "ethernet_rx_filter_crc_check_assert.svh"

module ethernet_rx_filter_crc_check
    import erfcc_pkg::*;
#(
    parameter int MAX_FRAME = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // payload_length[11:0], computed_check[43:12], zeros
    output logic [5:0]  m_axis_tuser,   // verdict[2:0], frame_type[5:3]
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_wdata
);

    logic [47:0] r_mac0, r_mac1;
    logic        r_out_valid;
    t_result     r_out;

    logic    w_in_valid, w_take, w_res_valid, w_out_free;
    t_beat   w_in_beat, w_s_beat;
    t_result w_res;

    assign w_s_beat   = '{data: s_axis_tdata, last: s_axis_tlast};
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac0 <= MAC0_RESET;
            r_mac1 <= MAC1_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAC0: r_mac0 <= i_cfg_wdata;
                CFG_MAC1: r_mac1 <= i_cfg_wdata;
                default:  r_mac0 <= r_mac0;
            endcase
        end
    end

    erfcc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_beat  (w_s_beat),
        .o_ready (s_axis_tready),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_beat  (w_in_beat)
    );

    erfcc_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_valid),
        .i_beat      (w_in_beat),
        .i_out_free  (w_out_free),
        .i_mac0      (r_mac0),
        .i_mac1      (r_mac1),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_result    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.computed_check, r_out.payload_length};
    assign m_axis_tuser  = {r_out.frame_type, r_out.verdict};

    // A new verdict only follows a final beat taken by the core.
    `ERFCC_ASSERT(a_verdict_from_last, (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(w_res_valid && w_in_beat.last), "verdict without a final beat")
    // A runt frame reports no payload and the CRC of no bytes.
    `ERFCC_ASSERT(a_runt_empty, (m_axis_tvalid && r_out.verdict == V_RUNT) |-> (r_out.payload_length == 12'd0 && r_out.computed_check == 32'd0), "runt verdict with payload")
    // A held beat in the input register is never overwritten.
    `ERFCC_ASSERT(a_in_hold, (w_in_valid && !w_take) |=> (w_in_valid && $stable(w_in_beat)), "input beat lost")
    // The core never produces a verdict into an occupied, stalled output register.
    `ERFCC_NEVER(a_no_overrun, w_res_valid && r_out_valid && !m_axis_tready, "verdict overrun")

endmodule

// File: rtl/erfcc_in_stage.sv
// Input register of the receive filter: holds one byte beat until the core takes it.
// Depends on erfcc_pkg for the beat type.
module erfcc_in_stage
    import erfcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_beat i_beat,
    output logic  o_ready,
    input  logic  i_take,
    output logic  o_valid,
    output t_beat o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

// File: rtl/erfcc_frame_core.sv
// Per-frame state of the receive filter: address match, ethertype, tail delay line,
// CRC-32 and byte count, and the verdict on the last byte. Depends on erfcc_pkg.
module erfcc_frame_core
    import erfcc_pkg::*;
#(
    parameter int MAX_FRAME = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_beat       i_beat,
    input  logic        i_out_free,
    input  logic [47:0] i_mac0,
    input  logic [47:0] i_mac1,
    output logic        o_take,
    output logic        o_res_valid,
    output t_result     o_result
);

    localparam int CW = $clog2(MAX_FRAME + 2);
    localparam int DW = (CW > 12) ? CW : 12;
    localparam logic [CW-1:0] CNT_SAT = CW'(MAX_FRAME + 1);

    logic [CW-1:0]     r_cnt,   n_cnt;
    logic [31:0]       r_crc,   n_crc;
    logic [3:0][7:0]   r_tail,  n_tail;
    logic [1:0]        r_match, n_match;
    logic [15:0]       r_type,  n_type;

    logic [7:0]    w_mac0_b, w_mac1_b;
    logic [DW-1:0] w_len, w_diff, w_pay;
    logic [31:0]   w_sum;
    logic          w_runt;

    // A plain byte never produces a result, so it moves on even while a verdict waits.
    assign o_take      = i_valid && (!i_beat.last || i_out_free);
    assign o_res_valid = o_take && i_beat.last;

    assign w_mac0_b = mac_byte(i_mac0, r_cnt[2:0]);
    assign w_mac1_b = mac_byte(i_mac1, r_cnt[2:0]);

    always_comb begin
        n_match = r_match;
        n_type  = r_type;
        n_crc   = r_crc;
        n_tail  = r_tail;
        if (r_cnt < CW'(MAC_BYTES)) begin
            if (w_mac0_b != i_beat.data) n_match[0] = 1'b0;
            if (w_mac1_b != i_beat.data) n_match[1] = 1'b0;
        end else if (r_cnt == CW'(TYPE_HI) || r_cnt == CW'(TYPE_LO)) begin
            n_type = {r_type[7:0], i_beat.data};
        end
        if (r_cnt >= CW'(HDR_LEN)) begin
            if (r_cnt >= CW'(HDR_LEN + 4)) begin
                n_crc = crc_byte(r_crc, r_tail[0]);
            end
            n_tail = {i_beat.data, r_tail[3:1]};
        end
        n_cnt = (r_cnt < CNT_SAT) ? r_cnt + CW'(1) : r_cnt;
    end

    assign w_len  = DW'(n_cnt);
    assign w_diff = w_len - DW'(MIN_FRAME);
    assign w_runt = w_len < DW'(MIN_FRAME);
    assign w_sum  = n_crc ^ CRC_XOROUT;

    always_comb begin
        if (w_runt) begin
            w_pay = '0;
        end else if (w_diff > DW'(PAYLOAD_CAP)) begin
            w_pay = DW'(PAYLOAD_CAP);
        end else begin
            w_pay = w_diff;
        end
    end

    always_comb begin
        priority if (w_runt) begin
            o_result.verdict = V_RUNT;
        end else if (w_len > DW'(MAX_FRAME)) begin
            o_result.verdict = V_OVERSIZE;
        end else if (n_match == 2'b00) begin
            o_result.verdict = V_ADDR_REJ;
        end else if (w_sum != 32'(n_tail)) begin
            o_result.verdict = V_CRC_REJ;
        end else begin
            o_result.verdict = V_ACCEPT;
        end
        o_result.frame_type     = type_class(n_type);
        o_result.payload_length = w_pay[11:0];
        o_result.computed_check = w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_crc   <= CRC_INIT;
            r_tail  <= '0;
            r_match <= 2'b11;
            r_type  <= '0;
        end else if (o_take) begin
            if (i_beat.last) begin
                r_cnt   <= '0;
                r_crc   <= CRC_INIT;
                r_tail  <= '0;
                r_match <= 2'b11;
                r_type  <= '0;
            end else begin
                r_cnt   <= n_cnt;
                r_crc   <= n_crc;
                r_tail  <= n_tail;
                r_match <= n_match;
                r_type  <= n_type;
            end
        end
    end

endmodule
